@@ src/sfr_pkg.sv @@
// shared types, register indexes and codes for the serial frame receiver
package sfr_pkg;

    localparam int PAYLOAD_MAX_DEF = 32;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_TYPE_MASK  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMER_ID   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GYRO_ID    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_END_BYTE   = 2'd3;

    localparam logic [7:0] RST_TYPE_MASK = 8'd240;
    localparam logic [7:0] RST_TIMER_ID  = 8'd16;
    localparam logic [7:0] RST_GYRO_ID   = 8'd32;
    localparam logic [7:0] RST_END_BYTE  = 8'd255;

    localparam logic [1:0] STAT_BUFFERING = 2'd0;
    localparam logic [1:0] STAT_FRAME_OK  = 2'd1;
    localparam logic [1:0] STAT_BAD_END   = 2'd2;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 3;

    typedef struct packed {
        logic [7:0] type_mask;
        logic [7:0] timer_id;
        logic [7:0] gyro_id;
        logic [7:0] end_byte;
    } t_cfg;

    typedef struct packed {
        logic [7:0] check_second;
        logic [7:0] check_first;
        logic [5:0] payload_len;
        logic [7:0] msg_type;
        logic [7:0] src_addr;
        logic [7:0] dest_addr;
        logic [7:0] payload_byte;
        logic [4:0] payload_index;
        logic       payload_valid;
        logic [1:0] status;
    } t_result;

endpackage

@@ src/sfr_cfg_regs.sv @@
// configuration registers of the serial frame receiver
module sfr_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sfr_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sfr_pkg::t_cfg                   o_cfg
);
    import sfr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.type_mask <= RST_TYPE_MASK;
            r_cfg.timer_id  <= RST_TIMER_ID;
            r_cfg.gyro_id   <= RST_GYRO_ID;
            r_cfg.end_byte  <= RST_END_BYTE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_TYPE_MASK: r_cfg.type_mask <= i_cfg_data;
                REG_TIMER_ID:  r_cfg.timer_id  <= i_cfg_data;
                REG_GYRO_ID:   r_cfg.gyro_id   <= i_cfg_data;
                REG_END_BYTE:  r_cfg.end_byte  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/sfr_parser.sv @@
// frame state machine: one received byte per transfer, one result per byte
module sfr_parser #(
    parameter int PAYLOAD_MAX = sfr_pkg::PAYLOAD_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_byte,
    input  sfr_pkg::t_cfg    i_cfg,
    output sfr_pkg::t_result o_result
);
    import sfr_pkg::*;

    localparam int LEN_W = $clog2(PAYLOAD_MAX + 1);

    localparam logic [2:0] PH_DEST = 3'd0;
    localparam logic [2:0] PH_SRC  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CHK1 = 3'd5;
    localparam logic [2:0] PH_CHK2 = 3'd6;
    localparam logic [2:0] PH_END  = 3'd7;

    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_dest, r_src, r_type, r_chk1, r_chk2;
    logic [LEN_W-1:0] r_len, r_count, n_count;
    logic [7:0]       kind;
    logic             dest_ok, len_bad, more_data;
    logic [7:0]       count_ext, len_ext;

    assign kind      = i_byte & i_cfg.type_mask;
    assign dest_ok   = (kind == i_cfg.timer_id) || (kind == i_cfg.gyro_id);
    assign len_bad   = (i_byte == 8'd0) || (9'(i_byte) > 9'(PAYLOAD_MAX));
    assign more_data = r_count < r_len;
    assign count_ext = 8'(r_count);
    assign len_ext   = 8'(r_len);

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        o_result = '0;
        unique case (r_phase)
            PH_DEST: n_phase = dest_ok ? PH_SRC : PH_DEST;
            PH_SRC:  n_phase = PH_TYPE;
            PH_TYPE: n_phase = PH_LEN;
            PH_LEN: begin
                n_phase = len_bad ? PH_DEST : PH_DATA;
                n_count = '0;
            end
            PH_DATA: begin
                if (more_data) begin
                    o_result.payload_valid = 1'b1;
                    o_result.payload_index = count_ext[4:0];
                    o_result.payload_byte  = i_byte;
                    n_count = r_count + LEN_W'(1);
                end else begin
                    // payload done, this byte is the first check byte
                    n_phase = PH_CHK2;
                end
            end
            PH_CHK1: n_phase = PH_CHK2;
            PH_CHK2: n_phase = PH_END;
            PH_END: begin
                n_phase = PH_DEST;
                if (i_byte == i_cfg.end_byte) begin
                    o_result.status       = STAT_FRAME_OK;
                    o_result.dest_addr    = r_dest;
                    o_result.src_addr     = r_src;
                    o_result.msg_type     = r_type;
                    o_result.payload_len  = len_ext[5:0];
                    o_result.check_first  = r_chk1;
                    o_result.check_second = r_chk2;
                end else begin
                    o_result.status = STAT_BAD_END;
                end
            end
            default: n_phase = PH_DEST;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DEST;
            r_count <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // frame fields are always written before the end byte reads them
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (r_phase)
                PH_DEST: r_dest <= i_byte;
                PH_SRC:  r_src  <= i_byte;
                PH_TYPE: r_type <= i_byte;
                PH_LEN:  r_len  <= i_byte[LEN_W-1:0];
                PH_DATA: if (!more_data) r_chk1 <= i_byte;
                PH_CHK1: r_chk1 <= i_byte;
                PH_CHK2: r_chk2 <= i_byte;
                default: ;
            endcase
        end
    end

endmodule

@@ src/sfr_skid.sv @@
// two-entry result register with skid stage between parser and output stream
module sfr_skid #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    logic             r_valid, r_skid_valid;
    logic [WIDTH-1:0] r_data, r_skid_data;
    logic             accept, load_main;

    assign o_ready   = !r_skid_valid;
    assign accept    = i_valid && o_ready;
    assign load_main = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load_main) begin
            r_valid      <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_main) begin
            r_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (accept) begin
            r_skid_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ src/serial_frame_receiver.sv @@
// Serial frame receiver top level. One received byte per transfer on the
// slave stream; each byte gives exactly one registered result transfer on
// the master stream, at a sustained rate of one byte per clock while the
// output is not stalled. A two-entry output register lets the input take
// one more byte while the output is stalled; the input stalls only when
// both entries are full. Frames are destination, source, type, length,
// payload, two check bytes and an end byte.
module serial_frame_receiver #(
    parameter int PAYLOAD_MAX = sfr_pkg::PAYLOAD_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sfr_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // rx_byte [7:0]
    input  logic [sfr_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // payload_index [4:0], payload_byte [12:5], dest_addr [20:13],
    // src_addr [28:21], msg_type [36:29], payload_len [42:37],
    // check_first [50:43], check_second [58:51], zero [63:59]
    output logic [sfr_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // status [1:0], payload_valid [2]
    output logic [sfr_pkg::M_TUSER_W-1:0]   o_m_tuser
);
    import sfr_pkg::*;

    t_cfg    cfg;
    t_result result, result_q;
    logic    in_xfer;

    assign in_xfer = i_s_tvalid && o_s_tready;

    sfr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sfr_parser #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (in_xfer),
        .i_byte   (i_s_tdata),
        .i_cfg    (cfg),
        .o_result (result)
    );

    sfr_skid #(
        .WIDTH ($bits(t_result))
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (result),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (result_q)
    );

    assign o_m_tuser = {result_q.payload_valid, result_q.status};
    assign o_m_tdata = {5'd0,
                        result_q.check_second,
                        result_q.check_first,
                        result_q.payload_len,
                        result_q.msg_type,
                        result_q.src_addr,
                        result_q.dest_addr,
                        result_q.payload_byte,
                        result_q.payload_index};

endmodule

@@ src/sfr_checker.sv @@
// port-level checks for the serial frame receiver, bound to the top level
module sfr_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            o_s_tready,
    input  logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [sfr_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input  logic [sfr_pkg::M_TUSER_W-1:0]   o_m_tuser
);
    import sfr_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled result changed");

    // input stalls only while a result is waiting
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !$past(i_m_tready))
        else $error("input stalled with output free");

    // a payload byte never comes with a frame status
    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2] |-> o_m_tuser[1:0] == STAT_BUFFERING)
        else $error("payload byte with frame status");

    // a good frame always carries a nonzero length
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1:0] == STAT_FRAME_OK |-> o_m_tdata[42:37] != 6'd0)
        else $error("good frame with zero length");

    // a byte accepted while the output is empty or being taken shows up next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (!o_m_tvalid || i_m_tready) |=> o_m_tvalid)
        else $error("accepted byte gave no result");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);
